FILE: sv/kdce_pkg.sv
// Package for the key-frame / delta coefficient encoder.
// Holds the sizes, codes and transaction types shared by every module of the block.
// No dependencies.
package kdce_pkg;

  // Store geometry.
  localparam int NUM_FIELDS  = 8;
  localparam int MAX_PATCHES = 4096;
  localparam int NUM_COEFFS  = 10;
  localparam int STORE_DEPTH = NUM_FIELDS * MAX_PATCHES * NUM_COEFFS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int FIELD_W = 3;
  localparam int PATCH_W = 12;
  localparam int COEFF_W = 4;
  localparam int VALUE_W = 32;
  localparam int FRAME_W = 16;
  localparam int TOL_W   = 31;

  // Remainder unit: one dividend bit per step.
  localparam int DIV_CNT_W = $clog2(FRAME_W);

  // Queue between the front and back ends.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_TOL    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_INTERVAL = 1'd1;
  localparam logic [TOL_W-1:0]     TOL_RESET        = 31'd655;
  localparam logic [FRAME_W-1:0]   INTERVAL_RESET   = 16'd100;

  // Result kinds.
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_DELTA = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0]        field_id;
    logic [PATCH_W-1:0]        patch_index;
    logic [COEFF_W-1:0]        coeff_index;
    logic signed [VALUE_W-1:0] coeff_value;
    logic [FRAME_W-1:0]        frame_number;
    logic                      last_coeff;
  } in_item_t;

  typedef struct packed {
    logic                      kind;
    logic [FIELD_W-1:0]        out_field;
    logic [PATCH_W-1:0]        out_patch;
    logic [COEFF_W-1:0]        out_coeff;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last_of_run;
  } out_item_t;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic [ADDR_W-1:0]         addr;
    logic [FIELD_W-1:0]        field_id;
    logic [PATCH_W-1:0]        patch_index;
    logic [COEFF_W-1:0]        coeff_index;
    logic signed [VALUE_W-1:0] coeff_value;
    logic                      last_coeff;
    logic                      key;
  } cls_item_t;

endpackage

FILE: sv/kdce_front.sv
// Front end of the encoder: accepts input transactions, drops out-of-range items,
// decides key frames with a bit-serial remainder unit and pushes the result to the queue.
// Depends on kdce_pkg.
module kdce_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kdce_pkg::in_item_t            in_item_i,
  input  logic [kdce_pkg::FRAME_W-1:0]  key_interval_i,
  output logic                          push_o,
  output kdce_pkg::cls_item_t           push_item_o,
  input  logic                          full_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e                       state_q, state_d;
  kdce_pkg::in_item_t                 item_q;
  logic                               key_q, key_d;
  logic [kdce_pkg::FRAME_W-1:0]       div_q, dvd_q, rem_q;
  logic [kdce_pkg::FRAME_W-1:0]       rem_next;
  logic [kdce_pkg::FRAME_W:0]         rem_shift;
  logic [kdce_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic                               accept;
  logic                               in_range;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);

  // Items addressing past the store are dropped without effect.
  assign in_range = (int'(in_item_i.field_id) < kdce_pkg::NUM_FIELDS) &&
                    (int'(in_item_i.patch_index) < kdce_pkg::MAX_PATCHES) &&
                    (int'(in_item_i.coeff_index) < kdce_pkg::NUM_COEFFS);

  // One restoring step of frame_number modulo key_interval.
  always_comb begin
    rem_shift = {rem_q, dvd_q[kdce_pkg::FRAME_W-1]};
    if (rem_shift >= {1'b0, div_q}) begin
      rem_next = kdce_pkg::FRAME_W'(rem_shift - {1'b0, div_q});
    end else begin
      rem_next = rem_shift[kdce_pkg::FRAME_W-1:0];
    end
  end

  // Next state and key decision.
  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept && in_range) begin
          if (in_item_i.frame_number == '0) begin
            key_d   = 1'b1;
            state_d = F_PUSH;
          end else if (key_interval_i == '0) begin
            key_d   = 1'b0;
            state_d = F_PUSH;
          end else begin
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (cnt_q == kdce_pkg::DIV_CNT_W'(kdce_pkg::FRAME_W - 1)) begin
          key_d   = (rem_next == '0);
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      key_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      if (state_q == F_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Item and divider datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      div_q  <= key_interval_i;
      dvd_q  <= in_item_i.frame_number;
      rem_q  <= '0;
    end else if (state_q == F_DIV) begin
      dvd_q <= {dvd_q[kdce_pkg::FRAME_W-2:0], 1'b0};
      rem_q <= rem_next;
    end
  end

  // Classified item toward the back end.
  always_comb begin
    push_item_o.addr = kdce_pkg::ADDR_W'(
        (kdce_pkg::ADDR_W'(item_q.field_id) * kdce_pkg::ADDR_W'(kdce_pkg::MAX_PATCHES) +
         kdce_pkg::ADDR_W'(item_q.patch_index)) * kdce_pkg::ADDR_W'(kdce_pkg::NUM_COEFFS) +
        kdce_pkg::ADDR_W'(item_q.coeff_index));
    push_item_o.field_id    = item_q.field_id;
    push_item_o.patch_index = item_q.patch_index;
    push_item_o.coeff_index = item_q.coeff_index;
    push_item_o.coeff_value = item_q.coeff_value;
    push_item_o.last_coeff  = item_q.last_coeff;
    push_item_o.key         = key_q;
  end

  assign push_o = (state_q == F_PUSH) && !full_i;

`ifndef SYNTHESIS
  // The remainder unit never runs with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> (div_q != '0))
    else $error("front: remainder step with zero divisor");

  // The last remainder step always hands over to the push state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == F_DIV) && (cnt_q == kdce_pkg::DIV_CNT_W'(kdce_pkg::FRAME_W - 1)))
      |=> (state_q == F_PUSH))
    else $error("front: remainder unit did not finish");
`endif

endmodule

FILE: sv/kdce_fifo.sv
// Short queue of classified items between the front and back ends.
// Depends on kdce_pkg.
module kdce_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kdce_pkg::cls_item_t push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output kdce_pkg::cls_item_t head_o,
  output logic                empty_o
);

  kdce_pkg::cls_item_t               entry_q [kdce_pkg::FIFO_DEPTH];
  logic [kdce_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [kdce_pkg::FIFO_CNT_W-1:0]   count_q;

  assign full_o  = (count_q == kdce_pkg::FIFO_CNT_W'(kdce_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == kdce_pkg::FIFO_PTR_W'(kdce_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == kdce_pkg::FIFO_PTR_W'(kdce_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  // Neither side may overrun or underrun the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> (!full_o || pop_i)) and (pop_i |-> !empty_o))
    else $error("fifo: overrun or underrun");
`endif

endmodule

FILE: sv/kdce_back.sv
// Back end of the encoder: owns the coefficient store, the patch difference buffer
// and the running maximum, and drives the output register. Depends on kdce_pkg.
module kdce_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [kdce_pkg::TOL_W-1:0]   delta_tol_i,
  input  kdce_pkg::cls_item_t          head_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output kdce_pkg::out_item_t          out_item_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_CALC = 3'b010,
    B_EMIT = 3'b100
  } back_state_e;

  back_state_e                          state_q, state_d;
  kdce_pkg::cls_item_t                  cur_q;
  logic [kdce_pkg::VALUE_W-1:0]         store_q [kdce_pkg::STORE_DEPTH];
  logic [kdce_pkg::VALUE_W-1:0]         rd_q;
  logic [kdce_pkg::VALUE_W-1:0]         buf_q [kdce_pkg::NUM_COEFFS];
  logic [kdce_pkg::VALUE_W-1:0]         buf_d [kdce_pkg::NUM_COEFFS];
  logic [kdce_pkg::VALUE_W-1:0]         max_q, max_d, max_new;
  logic [kdce_pkg::COEFF_W-1:0]         idx_q, idx_d;
  logic                                 out_valid_q, out_valid_d;
  kdce_pkg::out_item_t                  out_q, out_d;
  logic [kdce_pkg::VALUE_W:0]           diff, diff_neg;
  logic [kdce_pkg::VALUE_W-1:0]         mag, sat;
  logic                                 out_free;
  logic                                 store_wr;
  logic                                 emit_delta;

  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign store_wr    = (state_q == B_CALC);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Coefficient store: read when an item is popped, written back in the following cycle.
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[cur_q.addr] <= cur_q.coeff_value;
    end
    if (pop_o) begin
      rd_q <= store_q[head_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  // Exact difference, its magnitude and its saturated form.
  always_comb begin
    diff     = {cur_q.coeff_value[kdce_pkg::VALUE_W-1], cur_q.coeff_value} -
               {rd_q[kdce_pkg::VALUE_W-1], rd_q};
    diff_neg = '0 - diff;
    mag      = diff[kdce_pkg::VALUE_W] ? diff_neg[kdce_pkg::VALUE_W-1:0]
                                       : diff[kdce_pkg::VALUE_W-1:0];
    if (diff[kdce_pkg::VALUE_W] != diff[kdce_pkg::VALUE_W-1]) begin
      sat = diff[kdce_pkg::VALUE_W] ? {1'b1, {(kdce_pkg::VALUE_W-1){1'b0}}}
                                    : {1'b0, {(kdce_pkg::VALUE_W-1){1'b1}}};
    end else begin
      sat = diff[kdce_pkg::VALUE_W-1:0];
    end
    max_new    = (mag > max_q) ? mag : max_q;
    emit_delta = cur_q.last_coeff && (max_new > {1'b0, delta_tol_i});
  end

  // Sequencer, patch state and output register.
  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    max_d       = max_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          state_d = B_CALC;
        end
      end
      B_CALC: begin
        idx_d = '0;
        if (cur_q.key) begin
          // A key frame abandons any partial delta patch.
          for (int i = 0; i < kdce_pkg::NUM_COEFFS; i++) begin
            buf_d[i] = '0;
          end
          max_d   = '0;
          state_d = B_EMIT;
        end else begin
          buf_d[cur_q.coeff_index] = sat;
          max_d = max_new;
          if (emit_delta) begin
            state_d = B_EMIT;
          end else begin
            if (cur_q.last_coeff) begin
              for (int i = 0; i < kdce_pkg::NUM_COEFFS; i++) begin
                buf_d[i] = '0;
              end
              max_d = '0;
            end
            state_d = B_IDLE;
          end
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.out_field   = cur_q.field_id;
          out_d.out_patch   = cur_q.patch_index;
          if (cur_q.key) begin
            out_d.kind        = kdce_pkg::KIND_KEY;
            out_d.out_coeff   = cur_q.coeff_index;
            out_d.out_value   = cur_q.coeff_value;
            out_d.last_of_run = 1'b1;
            state_d           = B_IDLE;
          end else begin
            out_d.kind        = kdce_pkg::KIND_DELTA;
            out_d.out_coeff   = idx_q;
            out_d.out_value   = buf_q[idx_q];
            out_d.last_of_run = (idx_q == kdce_pkg::COEFF_W'(kdce_pkg::NUM_COEFFS - 1));
            idx_d             = idx_q + 1'b1;
            if (idx_q == kdce_pkg::COEFF_W'(kdce_pkg::NUM_COEFFS - 1)) begin
              for (int i = 0; i < kdce_pkg::NUM_COEFFS; i++) begin
                buf_d[i] = '0;
              end
              max_d   = '0;
              state_d = B_IDLE;
            end
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      max_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < kdce_pkg::NUM_COEFFS; i++) begin
        buf_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      max_q       <= max_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      buf_q       <= buf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  // The store update state is always left in the cycle after it is entered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CALC) |=> (state_q != B_CALC))
    else $error("back: update state lasted more than one cycle");

  // A delta run never walks past the last coefficient position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == B_EMIT) && !cur_q.key) |->
      (int'(idx_q) < kdce_pkg::NUM_COEFFS))
    else $error("back: emit index out of range");

  // A key-frame result is always a run of one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == kdce_pkg::KIND_KEY)) |-> out_q.last_of_run)
    else $error("back: key-frame result not marked last");
`endif

endmodule

FILE: sv/keyframe_delta_coefficient_encoder_core.sv
// Key-frame / delta coefficient encoder, top level.
// Input items carry one Q16.16 coefficient with its field, patch, position and frame.
// Key-frame items are stored and echoed as one result; delta-frame items update the
// store and, at a patch's last coefficient, release all ten differences of the patch
// when its largest change exceeds the tolerance.
// Channels: input and output use valid/stall; a transaction moves on a rising edge
// with valid high and stall low. Configuration uses valid/ready with a register index
// (0 delta tolerance, 1 key interval); it is always ready and must be written while idle.
// The front end takes a new item only after it has pushed the last one; when neither
// the frame number nor the key interval is zero it first runs the 16-step bit-serial
// remainder unit that tests frame_number against key_interval. The back end takes a
// delta item through its idle and update states and a key item also through its emit
// state; a released patch emits its ten results back to back without stall. A key-frame
// result passes from the queue through the idle, update and emit states to the output.
// A two-entry queue lets the front end keep classifying while the output is stalled.
// Reset clears all control state, the difference buffer and running maximum, and loads
// tolerance 655 and key interval 100; the coefficient store is not cleared and must be
// written by a key frame before a delta frame reads it. When the receiver stalls, the
// output register holds its result and the back end waits, then the queue fills.
// Depends on kdce_pkg, kdce_front, kdce_fifo and kdce_back.
module keyframe_delta_coefficient_encoder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  kdce_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output kdce_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kdce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kdce_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [kdce_pkg::TOL_W-1:0]   delta_tol_q;
  logic [kdce_pkg::FRAME_W-1:0] key_interval_q;
  logic                         push, full, pop, empty;
  kdce_pkg::cls_item_t          push_item, head;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_tol_q    <= kdce_pkg::TOL_RESET;
      key_interval_q <= kdce_pkg::INTERVAL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kdce_pkg::CFG_DELTA_TOL:    delta_tol_q    <= cfg_data_i[kdce_pkg::TOL_W-1:0];
        kdce_pkg::CFG_KEY_INTERVAL: key_interval_q <= cfg_data_i[kdce_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  kdce_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .key_interval_i (key_interval_q),
    .push_o         (push),
    .push_item_o    (push_item),
    .full_i         (full)
  );

  kdce_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  kdce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .delta_tol_i (delta_tol_q),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: tb/tb_keyframe_delta_coefficient_encoder_core.sv
// Self-checking testbench for keyframe_delta_coefficient_encoder_core.
// Drives a directed table and random patch sequences under several register settings.
// Depends on kdce_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_keyframe_delta_coefficient_encoder_core;
  import kdce_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 48;
  localparam int POOL_SIZE     = 6;
  localparam int PHASE_ITEMS   = 50;

  // One directed stimulus row; n_typed < 0 means the row is checked by the predictor.
  typedef struct {
    in_item_t  item;
    int        n_typed;
    out_item_t typed;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DELTA_TOL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: coefficient store, open patch and registers.
  logic [VALUE_W-1:0] coef_store [int unsigned];
  logic [VALUE_W-1:0] diff_buf [NUM_COEFFS];
  logic [VALUE_W-1:0] run_max;
  logic [TOL_W-1:0]   tol_reg = TOL_RESET;
  logic [FRAME_W-1:0] interval_reg = INTERVAL_RESET;

  out_item_t  expected_results [$];
  dir_row_t   dir_rows [$];
  int         pool_field [POOL_SIZE];
  int         pool_patch [POOL_SIZE];
  bit         pool_keyed [POOL_SIZE];
  int         mismatches = 0;
  int         items_sent = 0;
  int         key_results = 0;
  int         delta_results = 0;
  int         settings_used = 1;
  int         cycles = 0;
  bit         idle_en = 1'b1;
  bit         stall_en = 1'b1;

  keyframe_delta_coefficient_encoder_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL keyframe_delta_coefficient_encoder_core");
      $finish;
    end
  end

  function automatic int unsigned store_addr(input int f, input int p, input int c);
    return (f * MAX_PATCHES + p) * NUM_COEFFS + c;
  endfunction

  function automatic void clear_patch();
    foreach (diff_buf[j]) diff_buf[j] = '0;
    run_max = '0;
  endfunction

  // Computes the results of one item and updates the predictor state.
  function automatic void predict_encode(input in_item_t it, input bit queue_results);
    int unsigned        addr;
    logic               is_key;
    longint             diff;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] sat;
    out_item_t          r;
    if (it.field_id >= NUM_FIELDS || it.patch_index >= MAX_PATCHES ||
        it.coeff_index >= NUM_COEFFS) return;
    addr = store_addr(it.field_id, it.patch_index, it.coeff_index);
    is_key = (it.frame_number == 0) ||
             (interval_reg != 0 && (it.frame_number % interval_reg) == 0);
    r.out_field = it.field_id;
    r.out_patch = it.patch_index;
    if (is_key) begin
      coef_store[addr] = it.coeff_value;
      clear_patch();
      r.kind        = KIND_KEY;
      r.out_coeff   = it.coeff_index;
      r.out_value   = it.coeff_value;
      r.last_of_run = 1'b1;
      if (queue_results) expected_results.push_back(r);
      return;
    end
    diff = longint'($signed(it.coeff_value)) - longint'($signed(coef_store[addr]));
    mag = (diff < 0) ? VALUE_W'(-diff) : VALUE_W'(diff);
    if (diff > longint'(32'sh7FFFFFFF)) sat = 32'h7FFFFFFF;
    else if (diff < -longint'(32'sh7FFFFFFF) - 1) sat = 32'h80000000;
    else sat = diff[VALUE_W-1:0];
    diff_buf[it.coeff_index] = sat;
    if (mag > run_max) run_max = mag;
    coef_store[addr] = it.coeff_value;
    if (!it.last_coeff) return;
    if (run_max > {1'b0, tol_reg}) begin
      for (int j = 0; j < NUM_COEFFS; j++) begin
        r.kind        = KIND_DELTA;
        r.out_coeff   = COEFF_W'(j);
        r.out_value   = diff_buf[j];
        r.last_of_run = (j == NUM_COEFFS - 1);
        if (queue_results) expected_results.push_back(r);
      end
    end
    clear_patch();
  endfunction

  // Output side: random stall and comparison against the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: coeff %0d value %0d", out_item.out_coeff,
               $signed(out_item.out_value));
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (e.kind == KIND_KEY) key_results++;
        else delta_results++;
        if (out_item.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_item.kind);
          mismatches++;
        end
        if (out_item.out_field !== e.out_field) begin
          $error("out_field: expected %0d, got %0d", e.out_field, out_item.out_field);
          mismatches++;
        end
        if (out_item.out_patch !== e.out_patch) begin
          $error("out_patch: expected %0d, got %0d", e.out_patch, out_item.out_patch);
          mismatches++;
        end
        if (out_item.out_coeff !== e.out_coeff) begin
          $error("out_coeff: expected %0d, got %0d", e.out_coeff, out_item.out_coeff);
          mismatches++;
        end
        if (out_item.out_value !== e.out_value) begin
          $error("out_value: expected %0d, got %0d", $signed(e.out_value),
                 $signed(out_item.out_value));
          mismatches++;
        end
        if (out_item.last_of_run !== e.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", e.last_of_run,
                 out_item.last_of_run);
          mismatches++;
        end
      end
    end
    out_stall <= stall_en && ($urandom_range(0, 99) < 19);
  end

  // Presents one item, with an occasional gap first, and waits until it is taken.
  task automatic drive_item(input in_item_t it);
    if (idle_en && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input in_item_t it, input bit counted);
    predict_encode(it, 1'b1);
    drive_item(it);
    if (counted) items_sent++;
  endtask

  // Waits until every expected result has arrived and the pipeline has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers; the upper data bits carry noise that the block must drop.
  task automatic write_config(input logic [TOL_W-1:0] tol, input logic [FRAME_W-1:0] ivl);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DELTA_TOL;
    cfg_data  <= {1'($urandom_range(0, 1)), tol};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_KEY_INTERVAL;
    cfg_data  <= {16'($urandom), ivl};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_reg      = tol;
    interval_reg = ivl;
    settings_used++;
  endtask

  function automatic logic [FRAME_W-1:0] pick_key_frame();
    int unsigned k;
    if (interval_reg == 0) return '0;
    k = $urandom_range(0, 65535 / interval_reg);
    return FRAME_W'(k * interval_reg);
  endfunction

  // A frame that is not a key frame, unless the interval makes every frame one.
  function automatic logic [FRAME_W-1:0] pick_delta_frame();
    logic [FRAME_W-1:0] f;
    f = FRAME_W'($urandom_range(1, 65535));
    while (interval_reg > 1 && (f % interval_reg) == 0) f = FRAME_W'($urandom_range(1, 65535));
    return f;
  endfunction

  // New coefficient near the stored one; a quiet patch stays within the tolerance.
  function automatic logic [VALUE_W-1:0] next_value(input logic [VALUE_W-1:0] s,
                                                   input bit quiet);
    longint      d;
    int unsigned m;
    m = quiet ? $urandom_range(0, 69) : $urandom_range(0, 99);
    if (m < 60) d = longint'($urandom_range(0, int'(tol_reg)));
    else if (m < 70) d = longint'(tol_reg);
    else if (m < 80) d = longint'(tol_reg) + 1;
    else if (m < 90) return $urandom;
    else return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    if ($urandom_range(0, 1)) d = -d;
    return s + d[VALUE_W-1:0];
  endfunction

  // Key frame for every coefficient of a pool patch.
  task automatic key_sweep(input int slot);
    in_item_t           it;
    logic [FRAME_W-1:0] fr;
    fr = pick_key_frame();
    for (int c = 0; c < NUM_COEFFS; c++) begin
      it.field_id     = FIELD_W'(pool_field[slot]);
      it.patch_index  = PATCH_W'(pool_patch[slot]);
      it.coeff_index  = COEFF_W'(c);
      it.coeff_value  = $urandom;
      it.frame_number = fr;
      it.last_coeff   = (c == NUM_COEFFS - 1);
      send(it, 1'b1);
    end
    pool_keyed[slot] = 1'b1;
  endtask

  // Delta patch over a random subset of positions; a few are left open.
  task automatic delta_patch(input int slot);
    int                 order [NUM_COEFFS];
    int                 n;
    int                 k;
    int                 t;
    bit                 quiet;
    bit                 broken;
    logic [FRAME_W-1:0] fr;
    in_item_t           it;
    foreach (order[j]) order[j] = j;
    for (int j = NUM_COEFFS - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = order[j];
      order[j] = order[k];
      order[k] = t;
    end
    n      = $urandom_range(1, NUM_COEFFS);
    quiet  = $urandom_range(0, 99) < 40;
    broken = $urandom_range(0, 99) < 10;
    fr     = pick_delta_frame();
    for (int j = 0; j < n; j++) begin
      it.field_id     = FIELD_W'(pool_field[slot]);
      it.patch_index  = PATCH_W'(pool_patch[slot]);
      it.coeff_index  = COEFF_W'(order[j]);
      it.coeff_value  = next_value(
          coef_store[store_addr(pool_field[slot], pool_patch[slot], order[j])], quiet);
      it.frame_number = fr;
      it.last_coeff   = (j == n - 1) && !broken;
      send(it, 1'b1);
    end
  endtask

  // Random mix of noise, stray key items and well-formed patch sequences.
  task automatic run_random(input int target);
    int       sel;
    int       slot;
    in_item_t it;
    while (items_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        it = in_item_t'({$urandom, $urandom, 4'($urandom)});
        it.coeff_index = COEFF_W'($urandom_range(NUM_COEFFS, 15));
        send(it, 1'b0);
      end else if (sel < 25) begin
        it.field_id     = FIELD_W'($urandom);
        it.patch_index  = PATCH_W'($urandom);
        it.coeff_index  = COEFF_W'($urandom_range(0, NUM_COEFFS - 1));
        it.coeff_value  = $urandom;
        it.frame_number = pick_key_frame();
        it.last_coeff   = 1'($urandom);
        send(it, 1'b1);
      end else begin
        slot = $urandom_range(0, POOL_SIZE - 1);
        if (!pool_keyed[slot]) key_sweep(slot);
        else delta_patch(slot);
      end
    end
  endtask

  function automatic void add_row(input int f, input int p, input int c,
                                  input logic [31:0] v, input int fr, input bit l,
                                  input int nt, input logic [31:0] ev);
    dir_row_t r;
    r.item.field_id     = FIELD_W'(f);
    r.item.patch_index  = PATCH_W'(p);
    r.item.coeff_index  = COEFF_W'(c);
    r.item.coeff_value  = v;
    r.item.frame_number = FRAME_W'(fr);
    r.item.last_coeff   = l;
    r.n_typed           = nt;
    r.typed.kind        = KIND_KEY;
    r.typed.out_field   = FIELD_W'(f);
    r.typed.out_patch   = PATCH_W'(p);
    r.typed.out_coeff   = COEFF_W'(c);
    r.typed.out_value   = ev;
    r.typed.last_of_run = 1'b1;
    dir_rows.push_back(r);
  endfunction

  initial begin
    clear_patch();
    foreach (pool_field[i]) begin
      pool_field[i] = $urandom_range(0, NUM_FIELDS - 1);
      pool_patch[i] = $urandom_range(0, MAX_PATCHES - 1);
      pool_keyed[i] = 1'b0;
    end

    // Directed rows, valid under the reset tolerance of 655 and interval of 100.
    add_row(0, 0,    0,  32'h00000000, 0,     0, 1, 32'h00000000);
    add_row(7, 4095, 9,  32'h7FFFFFFF, 0,     1, 1, 32'h7FFFFFFF);
    add_row(7, 4095, 8,  32'h80000000, 100,   0, 1, 32'h80000000);
    // Out-of-range coefficient positions are dropped.
    add_row(2, 1,    15, 32'hFFFFFFFF, 65535, 1, 0, 32'h0);
    add_row(2, 1,    10, 32'h00000001, 3,     1, 0, 32'h0);
    add_row(1, 5,    0,  32'h00010000, 65500, 0, 1, 32'h00010000);
    add_row(1, 5,    1,  32'hFFFF0000, 65500, 1, 1, 32'hFFFF0000);
    // Largest change equal to the tolerance: nothing is released.
    add_row(1, 5,    0,  32'h0001028F, 1,     0, -1, 32'h0);
    add_row(1, 5,    1,  32'hFFFEFD71, 1,     1, -1, 32'h0);
    // One above the tolerance: the whole patch is released.
    add_row(1, 5,    1,  32'hFFFEFAE1, 2,     1, -1, 32'h0);
    // Differences that saturate in both directions.
    add_row(7, 4095, 9,  32'h80000000, 3,     0, -1, 32'h0);
    add_row(7, 4095, 8,  32'h7FFFFFFF, 3,     1, -1, 32'h0);
    // A key item abandons an open delta patch.
    add_row(1, 5,    0,  32'h7FFF0000, 4,     0, -1, 32'h0);
    add_row(1, 5,    1,  32'h00000005, 300,   0, 1, 32'h00000005);
    add_row(1, 5,    0,  32'h7FFF0001, 301,   1, -1, 32'h0);
    add_row(0, 0,    0,  32'hFFFFFFFF, 65535, 1, -1, 32'h0);
    add_row(3, 2048, 4,  32'h12345678, 200,   1, 1, 32'h12345678);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].n_typed < 0) begin
        predict_encode(dir_rows[i].item, 1'b1);
      end else begin
        predict_encode(dir_rows[i].item, 1'b0);
        if (dir_rows[i].n_typed == 1) expected_results.push_back(dir_rows[i].typed);
      end
      drive_item(dir_rows[i].item);
    end
    drain();

    // No gaps on either side while the smallest settings run.
    idle_en  = 1'b0;
    stall_en = 1'b0;
    write_config('0, '0);
    items_sent = 0;
    run_random(PHASE_ITEMS);
    drain();
    idle_en  = 1'b1;
    stall_en = 1'b1;

    write_config(31'h7FFFFFFF, 16'hFFFF);
    run_random(2 * PHASE_ITEMS);
    drain();

    write_config(31'd20, 16'd1);
    run_random(3 * PHASE_ITEMS);
    drain();

    write_config(TOL_W'($urandom_range(1, 100000)), FRAME_W'($urandom_range(2, 50)));
    run_random(4 * PHASE_ITEMS);
    drain();

    write_config(TOL_RESET, INTERVAL_RESET);
    run_random(5 * PHASE_ITEMS);
    drain();

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    $display("Ran %0d directed and %0d random coefficient items over %0d register settings.",
             dir_rows.size(), items_sent, settings_used);
    $display("Checked %0d key-frame and %0d delta results.", key_results, delta_results);
    if (mismatches == 0) begin
      $display("PASS keyframe_delta_coefficient_encoder_core");
    end else begin
      $display("FAIL keyframe_delta_coefficient_encoder_core");
    end
    $finish;
  end

endmodule
